// ===== rtl/core/krt_pkg.sv =====
// Shared types, codes and sizes for the keyed registration table.
// Used by krt_table_mem, krt_ctrl and keyed_registration_table.
package krt_pkg;

  // Capacity of the table and the widths that follow from it.
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths of the stream words.
  localparam int KEY_W    = 64;
  localparam int HANDLE_W = 32;
  localparam int OCNT_W   = 7;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } krt_cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_DUP       = 2'd2,
    ST_NOT_FOUND = 2'd3
  } krt_status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_MOVE_RD,
    FSM_MOVE_WR,
    FSM_RESP
  } krt_state_e;

  // One table entry as held in the memory.
  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } krt_entry_t;

  // Access request from the controller to the table memory.
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    krt_entry_t       wr_entry;
  } krt_mem_req_t;

  // Result of one request.
  typedef struct packed {
    krt_status_e         status;
    logic [HANDLE_W-1:0] found_handle;
    logic [OCNT_W-1:0]   entry_count;
  } krt_result_t;

endpackage

// ===== rtl/core/krt_table_mem.sv =====
// Entry storage of the keyed registration table: one write and one read port.
// Depends on krt_pkg for the entry and request types.
module krt_table_mem
  import krt_pkg::*;
(
  input  logic         clk_i,
  input  krt_mem_req_t req_i,
  output krt_entry_t   rd_entry_o
);

  krt_entry_t entries_q [TABLE_DEPTH];
  krt_entry_t rd_entry_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      entries_q[req_i.wr_addr] <= req_i.wr_entry;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_entry_q <= entries_q[req_i.rd_addr];
    end
  end

  assign rd_entry_o = rd_entry_q;

endmodule

// ===== rtl/core/krt_ctrl.sv =====
// Request sequencer of the keyed registration table: key scan, insert,
// swap-remove and clear. Depends on krt_pkg and drives krt_table_mem.
module krt_ctrl
  import krt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Request side
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  krt_cmd_e            req_cmd_i,
  input  logic [KEY_W-1:0]    req_key_i,
  input  logic [HANDLE_W-1:0] req_handle_i,
  // Memory side
  output krt_mem_req_t        mem_req_o,
  input  krt_entry_t          mem_rd_entry_i,
  // Result side
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output krt_result_t         res_o
);

  krt_state_e          state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  krt_cmd_e            cmd_q, cmd_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [HANDLE_W-1:0] handle_q, handle_d;
  logic [CNT_W-1:0]    rd_idx_q, rd_idx_d;
  logic                cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]    cmp_idx_q, cmp_idx_d;
  logic [IDX_W-1:0]    hit_idx_q, hit_idx_d;
  krt_status_e         res_status_q, res_status_d;
  logic [HANDLE_W-1:0] res_handle_q, res_handle_d;

  logic accept;
  logic issue;
  logic hit;
  logic miss;
  logic full;

  assign accept = req_valid_i && (state_q == FSM_IDLE);
  assign full   = (count_q == CNT_W'(TABLE_DEPTH));
  // A read goes out each scan cycle until all live slots are requested.
  assign issue  = (state_q == FSM_SCAN) && (rd_idx_q < count_q);
  // The compare stage looks at the word read in the previous cycle.
  assign hit    = (state_q == FSM_SCAN) && cmp_vld_q && (mem_rd_entry_i.key == key_q);
  assign miss   = (state_q == FSM_SCAN) && !cmp_vld_q && !issue;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          if (req_cmd_i == CMD_CLEAR) begin
            state_d = FSM_RESP;
          end else if (req_cmd_i == CMD_INSERT && full) begin
            state_d = FSM_RESP;
          end else begin
            state_d = FSM_SCAN;
          end
        end
      end
      FSM_SCAN: begin
        if (hit) begin
          state_d = (cmd_q == CMD_REMOVE) ? FSM_MOVE_RD : FSM_RESP;
        end else if (miss) begin
          state_d = FSM_RESP;
        end
      end
      FSM_MOVE_RD: state_d = FSM_MOVE_WR;
      FSM_MOVE_WR: state_d = FSM_RESP;
      FSM_RESP: begin
        if (res_ready_i) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    count_d      = count_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    handle_d     = handle_q;
    rd_idx_d     = rd_idx_q;
    cmp_vld_d    = issue;
    cmp_idx_d    = rd_idx_q[IDX_W-1:0];
    hit_idx_d    = hit_idx_q;
    res_status_d = res_status_q;
    res_handle_d = res_handle_q;

    mem_req_o.rd_en           = issue;
    mem_req_o.rd_addr         = rd_idx_q[IDX_W-1:0];
    mem_req_o.wr_en           = 1'b0;
    mem_req_o.wr_addr         = count_q[IDX_W-1:0];
    mem_req_o.wr_entry.key    = key_q;
    mem_req_o.wr_entry.handle = handle_q;

    unique case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          cmd_d        = req_cmd_i;
          key_d        = req_key_i;
          handle_d     = req_handle_i;
          rd_idx_d     = '0;
          res_status_d = ST_OK;
          res_handle_d = '0;
          if (req_cmd_i == CMD_CLEAR) begin
            count_d = '0;
          end else if (req_cmd_i == CMD_INSERT && full) begin
            res_status_d = ST_FULL;
          end
        end
      end
      FSM_SCAN: begin
        if (hit) begin
          unique case (cmd_q)
            CMD_INSERT: res_status_d = ST_DUP;
            CMD_REMOVE: begin
              res_handle_d = mem_rd_entry_i.handle;
              count_d      = count_q - 1'b1;
              hit_idx_d    = cmp_idx_q;
            end
            CMD_LOOKUP: res_handle_d = mem_rd_entry_i.handle;
            CMD_CLEAR:  res_status_d = ST_OK;
          endcase
        end else if (miss) begin
          if (cmd_q == CMD_INSERT) begin
            // Append at the current count.
            mem_req_o.wr_en = 1'b1;
            count_d         = count_q + 1'b1;
          end else begin
            res_status_d = ST_NOT_FOUND;
          end
        end else if (issue) begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
      end
      FSM_MOVE_RD: begin
        // Fetch the last live entry; count already points at it.
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = count_q[IDX_W-1:0];
      end
      FSM_MOVE_WR: begin
        // Move it into the freed slot; a self-copy when the hit was last.
        mem_req_o.wr_en    = 1'b1;
        mem_req_o.wr_addr  = hit_idx_q;
        mem_req_o.wr_entry = mem_rd_entry_i;
      end
      FSM_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FSM_IDLE;
      count_q   <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  // Request and scan payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    handle_q     <= handle_d;
    rd_idx_q     <= rd_idx_d;
    cmp_idx_q    <= cmp_idx_d;
    hit_idx_q    <= hit_idx_d;
    res_status_q <= res_status_d;
    res_handle_q <= res_handle_d;
  end

  assign req_ready_o      = (state_q == FSM_IDLE);
  assign res_valid_o      = (state_q == FSM_RESP);
  assign res_o.status       = res_status_q;
  assign res_o.found_handle = res_handle_q;
  assign res_o.entry_count  = OCNT_W'(count_q);

  // The live count never exceeds the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table capacity");

  // Memory writes happen only on an insert append or a remove move.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.wr_en |-> (state_q == FSM_SCAN && cmd_q == CMD_INSERT) ||
                        state_q == FSM_MOVE_WR)
    else $error("table write outside insert or remove");

  // A compare is pending only for a read issued in the scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> $past(state_q) == FSM_SCAN)
    else $error("compare stage valid outside scan");

  // The move write always comes in the cycle right after its read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FSM_MOVE_WR |-> $past(state_q) == FSM_MOVE_RD)
    else $error("move write without move read");

endmodule

// ===== rtl/core/keyed_registration_table.sv =====
// Keyed registration table: up to TABLE_DEPTH key/handle entries, unordered.
// Lookup, insert and remove scan the live slots through the table memory at
// one slot per cycle; a clear, or an insert refused on a full table, skips the scan.
// The result word is held in an output register; a held word stalls the next result.
// Reset clears the count and control; entry contents stay undefined until written.
module keyed_registration_table
  import krt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [95:0] s_axis_tdata_i,   // [63:0] search_key, [95:64] client_handle
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] cmd
  // Result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] found_handle, [38:32] entry_count, [39] zero
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);

  krt_mem_req_t mem_req;
  krt_entry_t   mem_rd_entry;
  logic         res_valid;
  logic         res_ready;
  krt_result_t  res;

  logic         out_vld_q, out_vld_d;
  krt_result_t  out_res_q;

  krt_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (s_axis_tvalid_i),
    .req_ready_o    (s_axis_tready_o),
    .req_cmd_i      (krt_cmd_e'(s_axis_tuser_i)),
    .req_key_i      (s_axis_tdata_i[KEY_W-1:0]),
    .req_handle_i   (s_axis_tdata_i[KEY_W+HANDLE_W-1:KEY_W]),
    .mem_req_o      (mem_req),
    .mem_rd_entry_i (mem_rd_entry),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res)
  );

  krt_table_mem u_mem (
    .clk_i      (clk_i),
    .req_i      (mem_req),
    .rd_entry_o (mem_rd_entry)
  );

  // Output register: takes a new result once the held word is gone.
  assign res_ready = !out_vld_q || m_axis_tready_i;

  always_comb begin
    out_vld_d = out_vld_q;
    if (res_valid && res_ready) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0, out_res_q.entry_count, out_res_q.found_handle};
  assign m_axis_tuser_o  = out_res_q.status;

endmodule
